// ===== rtl/sc2a_pkg.sv =====
`default_nettype none

package sc2a_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CHAR_W     = 7;
  localparam int CODE_W     = 8;
  localparam int MAP_LEN    = 60;

  localparam logic [CODE_W-1:0] CODE_LSHIFT_MAKE  = 8'h2A;
  localparam logic [CODE_W-1:0] CODE_LSHIFT_BREAK = 8'hAA;
  localparam logic [CODE_W-1:0] CODE_RSHIFT_MAKE  = 8'h36;
  localparam logic [CODE_W-1:0] CODE_RSHIFT_BREAK = 8'hB6;
  localparam logic [CODE_W-1:0] CODE_BREAK_BIT    = 8'h80;

  localparam logic FUNC_SCAN = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CHAR_W-1:0] char_t;

  // Flags carried from the accepting cycle to the cycle the RAM data arrives.
  typedef struct packed {
    logic pop;
    logic not_empty;
    logic dropped;
  } stage_flags_t;

  function automatic ptr_t next_slot(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  function automatic char_t plain_map(input logic [5:0] c);
    char_t r;
    case (c)
      6'd1:  r = 7'h1B;  6'd2:  r = 7'h31;  6'd3:  r = 7'h32;  6'd4:  r = 7'h33;
      6'd5:  r = 7'h34;  6'd6:  r = 7'h35;  6'd7:  r = 7'h36;  6'd8:  r = 7'h37;
      6'd9:  r = 7'h38;  6'd10: r = 7'h39;  6'd11: r = 7'h30;  6'd12: r = 7'h2D;
      6'd13: r = 7'h3D;  6'd14: r = 7'h08;  6'd15: r = 7'h09;  6'd16: r = 7'h71;
      6'd17: r = 7'h77;  6'd18: r = 7'h65;  6'd19: r = 7'h72;  6'd20: r = 7'h74;
      6'd21: r = 7'h79;  6'd22: r = 7'h75;  6'd23: r = 7'h69;  6'd24: r = 7'h6F;
      6'd25: r = 7'h70;  6'd26: r = 7'h5B;  6'd27: r = 7'h5D;  6'd28: r = 7'h0A;
      6'd30: r = 7'h61;  6'd31: r = 7'h73;  6'd32: r = 7'h64;  6'd33: r = 7'h66;
      6'd34: r = 7'h67;  6'd35: r = 7'h68;  6'd36: r = 7'h6A;  6'd37: r = 7'h6B;
      6'd38: r = 7'h6C;  6'd39: r = 7'h3B;  6'd40: r = 7'h27;  6'd41: r = 7'h60;
      6'd43: r = 7'h5C;  6'd44: r = 7'h7A;  6'd45: r = 7'h78;  6'd46: r = 7'h63;
      6'd47: r = 7'h76;  6'd48: r = 7'h62;  6'd49: r = 7'h6E;  6'd50: r = 7'h6D;
      6'd51: r = 7'h2C;  6'd52: r = 7'h2E;  6'd53: r = 7'h2F;  6'd55: r = 7'h2A;
      6'd57: r = 7'h20;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic char_t shifted_map(input logic [5:0] c);
    char_t r;
    case (c)
      6'd1:  r = 7'h1B;  6'd2:  r = 7'h21;  6'd3:  r = 7'h40;  6'd4:  r = 7'h23;
      6'd5:  r = 7'h24;  6'd6:  r = 7'h25;  6'd7:  r = 7'h5E;  6'd8:  r = 7'h26;
      6'd9:  r = 7'h2A;  6'd10: r = 7'h28;  6'd11: r = 7'h29;  6'd12: r = 7'h5F;
      6'd13: r = 7'h2B;  6'd14: r = 7'h08;  6'd15: r = 7'h09;  6'd16: r = 7'h51;
      6'd17: r = 7'h57;  6'd18: r = 7'h45;  6'd19: r = 7'h52;  6'd20: r = 7'h54;
      6'd21: r = 7'h59;  6'd22: r = 7'h55;  6'd23: r = 7'h49;  6'd24: r = 7'h4F;
      6'd25: r = 7'h50;  6'd26: r = 7'h7B;  6'd27: r = 7'h7D;  6'd28: r = 7'h0A;
      6'd30: r = 7'h41;  6'd31: r = 7'h53;  6'd32: r = 7'h44;  6'd33: r = 7'h46;
      6'd34: r = 7'h47;  6'd35: r = 7'h48;  6'd36: r = 7'h4A;  6'd37: r = 7'h4B;
      6'd38: r = 7'h4C;  6'd39: r = 7'h3A;  6'd40: r = 7'h22;  6'd41: r = 7'h7E;
      6'd43: r = 7'h7C;  6'd44: r = 7'h5A;  6'd45: r = 7'h58;  6'd46: r = 7'h43;
      6'd47: r = 7'h56;  6'd48: r = 7'h42;  6'd49: r = 7'h4E;  6'd50: r = 7'h4D;
      6'd51: r = 7'h3C;  6'd52: r = 7'h3E;  6'd53: r = 7'h3F;  6'd55: r = 7'h2A;
      6'd57: r = 7'h20;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sc2a_ram.sv =====
`default_nettype none

module sc2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scancode_to_ascii_fifo.sv =====
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid / in_stall  func, scan_code
// output    out_valid / out_stall read_char, not_empty, dropped
//
// One beat is accepted per cycle while in_stall is low; its result passes through
// the RAM stage and then the output register. Pointers and the shift flag update in
// the accepting cycle; the RAM stage waits for the registered character RAM read.
// Reset clears the pointers, the shift flag and both valid bits; the RAM is not cleared.
// A stalled output holds the result register, and the input stalls only when
// both the RAM stage and the output register are full.

module scancode_to_ascii_fifo (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         func,
  input  wire logic [sc2a_pkg::CODE_W-1:0]  scan_code,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [sc2a_pkg::CHAR_W-1:0]  read_char,
  output logic                              not_empty,
  output logic                              dropped
);

  sc2a_pkg::ptr_t         write_ptr, write_ptr_next;
  sc2a_pkg::ptr_t         read_ptr, read_ptr_next;
  logic                   shift_held, shift_held_next;
  logic                   s1_valid;
  sc2a_pkg::stage_flags_t s1_flags, s1_flags_next;
  sc2a_pkg::char_t        ram_q;
  sc2a_pkg::char_t        decoded;
  logic                   accept, s1_adv, push, full;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    decoded = '0;
    if (scan_code < sc2a_pkg::CODE_W'(sc2a_pkg::MAP_LEN)) begin
      decoded = shift_held ? sc2a_pkg::shifted_map(scan_code[5:0])
                           : sc2a_pkg::plain_map(scan_code[5:0]);
    end
  end

  assign full = sc2a_pkg::next_slot(write_ptr) == read_ptr;

  always_comb begin
    write_ptr_next  = write_ptr;
    read_ptr_next   = read_ptr;
    shift_held_next = shift_held;
    push            = 1'b0;
    s1_flags_next   = '0;
    if (func == sc2a_pkg::FUNC_READ) begin
      if (read_ptr != write_ptr) begin
        s1_flags_next.pop = 1'b1;
        read_ptr_next     = sc2a_pkg::next_slot(read_ptr);
      end
    end else if (scan_code == sc2a_pkg::CODE_LSHIFT_MAKE ||
                 scan_code == sc2a_pkg::CODE_RSHIFT_MAKE) begin
      shift_held_next = 1'b1;
    end else if (scan_code == sc2a_pkg::CODE_LSHIFT_BREAK ||
                 scan_code == sc2a_pkg::CODE_RSHIFT_BREAK) begin
      shift_held_next = 1'b0;
    end else if ((scan_code & sc2a_pkg::CODE_BREAK_BIT) == '0 && decoded != '0) begin
      if (!full) begin
        push           = 1'b1;
        write_ptr_next = sc2a_pkg::next_slot(write_ptr);
      end else begin
        s1_flags_next.dropped = 1'b1;
      end
    end
    s1_flags_next.not_empty = read_ptr_next != write_ptr_next;
  end

  sc2a_ram #(
    .WIDTH (sc2a_pkg::CHAR_W),
    .DEPTH (sc2a_pkg::FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && push),
    .waddr (write_ptr),
    .wdata (decoded),
    .re    (accept && s1_flags_next.pop),
    .raddr (read_ptr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr  <= '0;
      read_ptr   <= '0;
      shift_held <= 1'b0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        write_ptr  <= write_ptr_next;
        read_ptr   <= read_ptr_next;
        shift_held <= shift_held_next;
        s1_valid   <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags <= s1_flags_next;
    end
    if (s1_adv) begin
      read_char <= s1_flags.pop ? ram_q : '0;
      not_empty <= s1_flags.not_empty;
      dropped   <= s1_flags.dropped;
    end
  end

  // A beat waiting for the output register must not be overwritten.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid && $stable(s1_flags))
    else $error("RAM stage lost a beat while the output stalled");

  a_no_spurious_stall: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with an empty RAM stage");

  a_pop_advances: assert property (@(posedge clk) disable iff (rst)
    accept && s1_flags_next.pop |=> read_ptr == sc2a_pkg::next_slot($past(read_ptr)))
    else $error("read pointer did not advance on a pop");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    accept && s1_flags_next.dropped |-> full && write_ptr_next == write_ptr)
    else $error("character dropped while the FIFO had room");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (sc2a_pkg::PTR_W+1)'(write_ptr) < (sc2a_pkg::PTR_W+1)'(sc2a_pkg::FIFO_DEPTH))
    else $error("write pointer out of range");

endmodule

`default_nettype wire
